// ===== src/wddc_pkg.sv =====
// wddc_pkg: types and constants for the windowed duplicate digest canceller
// no dependencies; used by windowed_duplicate_digest_canceller_unit

package wddc_pkg;

   localparam int THRESH_W = 7;
   localparam int TAG_W    = 32;
   localparam int HALF_W   = 64;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd2;

   localparam logic KIND_NOTICE  = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NOTIFY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [HALF_W-1:0] digest_high;
      logic [HALF_W-1:0] digest_low;
      logic [TAG_W-1:0]  tag;
      logic              intentional;
      logic              cancelled;
   } slot_type;

endpackage

// ===== src/windowed_duplicate_digest_canceller_unit.sv =====
// windowed_duplicate_digest_canceller_unit: ring of recent digests in one slot memory, a count
//   pass and a notice pass over the ring, then the verdict request; depends on wddc_pkg
// steps: e = earlier entries (up to WINDOW_SLOTS-2); accept, a count pass over the e entries,
//   a notice pass over them when it runs, then the verdict; output stalls hold notices and verdict
// one request at a time: a new request is accepted only after the verdict of the last one
// reset: synchronous, empties the ring, threshold back to 2; slot memory is not cleared

module windowed_duplicate_digest_canceller_unit #(
   parameter int WINDOW_SLOTS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wddc_pkg::HALF_W-1:0]      req_digest_high,
   input  logic [wddc_pkg::HALF_W-1:0]      req_digest_low,
   input  logic [wddc_pkg::TAG_W-1:0]       req_msg_tag,
   input  logic                             req_intentional_dupe,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic                             rsp_cancelled,
   output logic [wddc_pkg::TAG_W-1:0]       rsp_cancel_tag,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wddc_pkg::THRESH_W-1:0]    csr_dupe_threshold
);
   import wddc_pkg::*;

   localparam int IDX_W = (WINDOW_SLOTS > 2) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
   localparam int CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   slot_type slot_mem [WINDOW_SLOTS];
   slot_type rd_data_ff;

   state_type state_ff, state_in;
   logic [THRESH_W-1:0] thresh_ff;
   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in, addr_ff, addr_in;
   logic [CNT_W-1:0] earlier_ff, earlier_in, left_ff, left_in;
   logic [CNT_W-1:0] nmatch_ff, nmatch_in, nintent_ff, nintent_in;
   logic found_ff, found_in, prev_canc_ff, prev_canc_in, canc_ff, canc_in;
   logic dv_ff, dv_in;
   slot_type cur_ff, cur_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic rsp_canc_ff, rsp_canc_in, rsp_last_ff, rsp_last_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;

   logic out_free, rd_en, mem_we, stall, hit;
   logic [IDX_W-1:0] nexthead, tail_new;
   logic [CNT_W-1:0] occ;
   logic [CMP_W-1:0] excess;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_cancelled  = rsp_canc_ff;
   assign rsp_cancel_tag = rsp_tag_ff;
   assign rsp_last       = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = (rd_data_ff.digest_high == cur_ff.digest_high)
                     && (rd_data_ff.digest_low == cur_ff.digest_low);
   assign stall    = (state_ff == ST_NOTIFY) && dv_ff && hit
                     && !rd_data_ff.cancelled && !out_free;
   assign nexthead = idx_next(head_ff);
   assign tail_new = (nexthead == tail_ff) ? idx_next(tail_ff) : tail_ff;
   assign occ      = (nexthead >= tail_new)
                     ? CNT_W'(nexthead - tail_new)
                     : CNT_W'(CNT_W'(nexthead) + CNT_W'(WINDOW_SLOTS) - CNT_W'(tail_new));
   assign excess   = CMP_W'(nmatch_ff - nintent_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_idx_in   = cur_idx_ff;
      addr_in      = addr_ff;
      earlier_in   = earlier_ff;
      left_in      = left_ff;
      nmatch_in    = nmatch_ff;
      nintent_in   = nintent_ff;
      found_in     = found_ff;
      prev_canc_in = prev_canc_ff;
      canc_in      = canc_ff;
      dv_in        = dv_ff;
      cur_in       = cur_ff;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_canc_in  = rsp_canc_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in.digest_high = req_digest_high;
               cur_in.digest_low  = req_digest_low;
               cur_in.tag         = req_msg_tag;
               cur_in.intentional = req_intentional_dupe;
               cur_in.cancelled   = 1'b0;
               cur_idx_in   = head_ff;
               head_in      = nexthead;
               tail_in      = tail_new;
               earlier_in   = occ - 1'b1;
               left_in      = occ - 1'b1;
               addr_in      = idx_prev(head_ff);
               nmatch_in    = CNT_W'(1);
               nintent_in   = CNT_W'(req_intentional_dupe);
               found_in     = 1'b0;
               prev_canc_in = 1'b0;
               canc_in      = 1'b0;
               dv_in        = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN, ST_NOTIFY: begin
            if (!stall) begin
               if (dv_ff && hit) begin
                  if (state_ff == ST_SCAN) begin
                     nmatch_in  = nmatch_ff + 1'b1;
                     nintent_in = nintent_ff + CNT_W'(rd_data_ff.intentional);
                     if (!found_ff) begin
                        found_in     = 1'b1;
                        prev_canc_in = rd_data_ff.cancelled;
                     end
                  end else if (!rd_data_ff.cancelled) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_NOTICE;
                     rsp_canc_in  = 1'b0;
                     rsp_tag_in   = rd_data_ff.tag;
                     rsp_last_in  = 1'b0;
                  end
               end
               if (left_ff != '0) begin
                  rd_en   = 1'b1;
                  dv_in   = 1'b1;
                  left_in = left_ff - 1'b1;
                  addr_in = idx_prev(addr_ff);
               end else begin
                  dv_in = 1'b0;
                  if (!dv_ff) begin
                     if (state_ff == ST_NOTIFY) begin
                        state_in = ST_FINISH;
                     end else if (prev_canc_ff) begin
                        canc_in  = 1'b1;
                        state_in = ST_FINISH;
                     end else if (excess >= CMP_W'(thresh_ff)) begin
                        canc_in  = 1'b1;
                        left_in  = earlier_ff;
                        addr_in  = idx_prev(cur_idx_ff);
                        state_in = ST_NOTIFY;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_VERDICT;
               rsp_canc_in  = canc_ff;
               rsp_tag_in   = cur_ff.tag;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[cur_idx_ff] <= '{digest_high: cur_ff.digest_high,
                                   digest_low:  cur_ff.digest_low,
                                   tag:         cur_ff.tag,
                                   intentional: cur_ff.intentional,
                                   cancelled:   canc_ff};
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            thresh_ff <= csr_dupe_threshold;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff   <= cur_idx_in;
      addr_ff      <= addr_in;
      earlier_ff   <= earlier_in;
      left_ff      <= left_in;
      nmatch_ff    <= nmatch_in;
      nintent_ff   <= nintent_in;
      found_ff     <= found_in;
      prev_canc_ff <= prev_canc_in;
      canc_ff      <= canc_in;
      cur_ff       <= cur_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_canc_ff  <= rsp_canc_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // a busy request always holds its own entry in the ring
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (head_ff != tail_ff))
      else $error("ring empty while a request is in flight");

   // read data is only in flight during a pass
   assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_NOTIFY)))
      else $error("read data outside a pass");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (left_ff <= earlier_ff))
      else $error("pass walks past the earlier entries");

   // verdict leaves finish on the next edge with the last flag
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid && rsp_last && rsp_kind))
      else $error("verdict not presented");

endmodule
